[rtl/ahfp_pkg.sv]
// Shared types, constants and hex decode helpers for the addressed hex frame parser.
package ahfp_pkg;

  localparam int MAX_BYTES = 5;
  localparam int COUNT_CAP = 7;
  localparam logic [2:0] BYTE_LIMIT = 3'((MAX_BYTES > COUNT_CAP) ? COUNT_CAP : MAX_BYTES);

  localparam logic [7:0] CH_START = 8'h21;  // '!'
  localparam logic [7:0] CH_END   = 8'h2E;  // '.'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] ALPHA_OFS = 8'h37;  // 'A' - 10

  localparam logic [1:0] PH_ADDR = 2'd0;
  localparam logic [1:0] PH_TAKE = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  localparam logic BOARD_ADDR_IDX = 1'b0;
  localparam logic [7:0] BOARD_ADDR_RST = 8'd20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic [2:0] byte_count;
    logic       overflowed;
  } res_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] d;
    c = ch;
    if (c >= CH_LA && c <= CH_LZ) begin
      c = c - CASE_OFS;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - ALPHA_OFS;
      hex_digit = {1'b1, d[3:0]};
    end else begin
      hex_digit = 5'd0;
    end
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    h = hex_digit(hi);
    l = hex_digit(lo);
    pair_value = (h[4] && l[4]) ? {h[3:0], l[3:0]} : 8'd0;
  endfunction

endpackage

[rtl/addressed_hex_frame_parser.sv]
// Addressed hex frame parser: character state machine, APB register and output buffer.
//
// One ASCII character is taken per clock while in_ready is high. A request is decoded
// in the cycle it is accepted and its result, if any, is registered into the output
// register, or into the skid register when an older result is still waiting. The
// output side is a two-entry buffer (output register plus skid register), so the
// input keeps taking a character every cycle while the consumer stalls, until both
// entries are full; in_ready drops only once both entries are full. '!' restarts a
// frame at any point; the first two characters form the address, compared against
// board_address (APB offset 0x0, reset 20).
module addressed_hex_frame_parser import ahfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       frame_end,
  output logic [2:0] byte_count,
  output logic       overflowed
);

  logic [7:0] board_address;
  logic [1:0] phase, phase_next;
  logic       addr_digit_seen, addr_digit_seen_next;
  logic [7:0] first_char, first_char_next;
  logic       pair_pending, pair_pending_next;
  logic [2:0] kept_count, kept_count_next;
  logic       overflow_flag, overflow_flag_next;

  logic       res_valid;
  res_t       res;
  res_t       out_res;
  res_t       skid_res;
  logic       skid_valid;
  logic       in_acc;
  logic       out_pop;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == BOARD_ADDR_IDX) ? {24'd0, board_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_address <= BOARD_ADDR_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == BOARD_ADDR_IDX) begin
      board_address <= pwdata[7:0];
    end
  end

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign out_pop  = out_valid && out_ready;

  // Per-character decode
  always_comb begin
    phase_next           = phase;
    addr_digit_seen_next = addr_digit_seen;
    first_char_next      = first_char;
    pair_pending_next    = pair_pending;
    kept_count_next      = kept_count;
    overflow_flag_next   = overflow_flag;
    res_valid            = 1'b0;
    res                  = '0;
    if (rx_byte == CH_START) begin
      phase_next           = PH_ADDR;
      addr_digit_seen_next = 1'b0;
      pair_pending_next    = 1'b0;
      kept_count_next      = 3'd0;
      overflow_flag_next   = 1'b0;
    end else begin
      unique case (phase)
        PH_ADDR: begin
          if (!addr_digit_seen) begin
            first_char_next      = rx_byte;
            addr_digit_seen_next = 1'b1;
          end else begin
            addr_digit_seen_next = 1'b0;
            pair_pending_next    = 1'b0;
            kept_count_next      = 3'd0;
            overflow_flag_next   = 1'b0;
            phase_next = (pair_value(first_char, rx_byte) == board_address) ? PH_TAKE : PH_SKIP;
          end
        end
        PH_TAKE: begin
          if (rx_byte == CH_END) begin
            res_valid         = 1'b1;
            res.frame_end     = 1'b1;
            res.byte_count    = kept_count;
            res.overflowed    = overflow_flag;
            phase_next        = PH_SKIP;
            pair_pending_next = 1'b0;
          end else if (!pair_pending) begin
            first_char_next   = rx_byte;
            pair_pending_next = 1'b1;
          end else begin
            pair_pending_next = 1'b0;
            if (kept_count >= BYTE_LIMIT) begin
              overflow_flag_next = 1'b1;
            end else begin
              kept_count_next = kept_count + 3'd1;
              res_valid       = 1'b1;
              res.data_byte   = pair_value(first_char, rx_byte);
              res.byte_count  = kept_count + 3'd1;
              res.overflowed  = overflow_flag;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ADDR;
      addr_digit_seen <= 1'b0;
      first_char      <= 8'd0;
      pair_pending    <= 1'b0;
      kept_count      <= 3'd0;
      overflow_flag   <= 1'b0;
    end else if (in_acc) begin
      phase           <= phase_next;
      addr_digit_seen <= addr_digit_seen_next;
      first_char      <= first_char_next;
      pair_pending    <= pair_pending_next;
      kept_count      <= kept_count_next;
      overflow_flag   <= overflow_flag_next;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (in_acc && res_valid) begin
        if (!out_valid || out_pop) begin
          out_valid <= 1'b1;
          if (skid_valid) begin
            skid_valid <= 1'b1;
          end
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      if (!out_valid || out_pop) begin
        if (skid_valid) begin
          out_res  <= skid_res;
          skid_res <= res;
        end else begin
          out_res <= res;
        end
      end else begin
        skid_res <= res;
      end
    end else if (out_pop && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign data_byte  = out_res.data_byte;
  assign frame_end  = out_res.frame_end;
  assign byte_count = out_res.byte_count;
  assign overflowed = out_res.overflowed;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && rx_byte == CH_START |=>
      phase == PH_ADDR && kept_count == 3'd0 && !overflow_flag && !addr_digit_seen)
    else $error("frame start did not clear frame state");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> kept_count == BYTE_LIMIT)
    else $error("overflow flagged below byte limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= BYTE_LIMIT)
    else $error("kept byte count beyond limit");

  a_byte_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> byte_count != 3'd0)
    else $error("payload byte request with zero count");

endmodule
